// ===== hdl/kpsd_pkg.sv =====
package kpsd_pkg;

  localparam int unsigned DIGITS_DEFAULT = 8;
  localparam logic [15:0] DEBOUNCE_RESET = 16'd3000;
  localparam logic [15:0] DWELL_RESET    = 16'd150;

  localparam int unsigned CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_DWELL    = CFG_INDEX_W'(1);

  localparam logic [7:0] SEG_BLANK = 8'h00;

  typedef struct packed {
    logic       en;
    logic [3:0] key;
  } kpsd_push_t;

  function automatic logic [7:0] seg_code(input logic [3:0] key);
    logic [7:0] s;
    unique case (key)
      4'h0: s = 8'h3f;
      4'h1: s = 8'h06;
      4'h2: s = 8'h5b;
      4'h3: s = 8'h4f;
      4'h4: s = 8'h66;
      4'h5: s = 8'h6d;
      4'h6: s = 8'h7d;
      4'h7: s = 8'h07;
      4'h8: s = 8'h7f;
      4'h9: s = 8'h6f;
      4'ha: s = 8'h77;
      4'hb: s = 8'h7c;
      4'hc: s = 8'h39;
      4'hd: s = 8'h5e;
      4'he: s = 8'h79;
      default: s = 8'h71;
    endcase
    return s;
  endfunction

  // index is {column, row}
  function automatic logic [3:0] key_map(input logic [3:0] col_row);
    logic [3:0] k;
    unique case (col_row)
      4'h0: k = 4'd7;
      4'h1: k = 4'd4;
      4'h2: k = 4'd1;
      4'h3: k = 4'd10;
      4'h4: k = 4'd8;
      4'h5: k = 4'd5;
      4'h6: k = 4'd2;
      4'h7: k = 4'd0;
      4'h8: k = 4'd9;
      4'h9: k = 4'd6;
      4'ha: k = 4'd3;
      4'hb: k = 4'd11;
      4'hc: k = 4'd12;
      4'hd: k = 4'd13;
      4'he: k = 4'd14;
      default: k = 4'd15;
    endcase
    return k;
  endfunction

endpackage

// ===== hdl/kpsd_display_store.sv =====
module kpsd_display_store import kpsd_pkg::*; #(
  parameter int unsigned DIGITS = DIGITS_DEFAULT,
  localparam int unsigned DigW = (DIGITS > 1) ? $clog2(DIGITS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kpsd_push_t      push_i,
  input  logic [DigW-1:0] rd_idx_i,
  output logic [7:0]      rd_seg_o
);

  logic [7:0] codes_q [DIGITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIGITS; i++) codes_q[i] <= SEG_BLANK;
    end else if (push_i.en) begin
      for (int i = 0; i + 1 < DIGITS; i++) codes_q[i] <= codes_q[i+1];
      codes_q[DIGITS-1] <= seg_code(push_i.key);
    end
  end

  assign rd_seg_o = codes_q[rd_idx_i];

endmodule

// ===== hdl/keypad_to_scrolling_segment_display.sv =====
// Keypad scanner with a scrolling multiplexed seven-segment display. Every
// request is one timing tick carrying the sensed row lines, and it yields
// exactly one result: the column, digit and segment lines for that tick plus
// a key strobe and key code. A new request is taken every cycle while the
// result register is empty or being drained, so throughput is one tick per
// cycle, set by the single pass from the input through the frame sequencer
// (scan/debounce counter and digit store) into the result register. A frame
// is four column scans, each possibly stretched by debounce_ticks+1 ticks,
// followed by DIGITS display phases of dwell_ticks ticks each (one tick when
// dwell_ticks is zero).
module keypad_to_scrolling_segment_display import kpsd_pkg::*; #(
  parameter int unsigned DIGITS = DIGITS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [15:0]            cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [3:0]             row_sense_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [3:0]             column_drive_o,
  output logic [7:0]             digit_select_o,
  output logic [7:0]             segment_pattern_o,
  output logic                   key_accepted_o,
  output logic [3:0]             key_code_o
);

  localparam int unsigned PhaseW = $clog2(DIGITS + 4);
  localparam int unsigned DigW   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [PhaseW-1:0] PhaseDisp = PhaseW'(4);
  localparam logic [PhaseW-1:0] PhaseLast = PhaseW'(DIGITS + 3);

  logic [15:0]       debounce_q, dwell_q;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic              wait_q, wait_d;
  logic [15:0]       cnt_q, cnt_d;
  logic [4:0]        found_q, found_d;
  logic [3:0]        col_q, col_d;
  logic [7:0]        dig_q, dig_d;
  logic [7:0]        seg_q, seg_d;
  logic              acc_q, acc_d;
  logic [3:0]        code_q, code_d;
  logic              out_valid_q;
  logic              in_fire;
  kpsd_push_t        push;
  logic [DigW-1:0]   rd_idx;
  logic [7:0]        rd_seg;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
      dwell_q    <= DWELL_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_DEBOUNCE) debounce_q <= cfg_data_i;
      if (cfg_index_i == REG_DWELL)    dwell_q    <= cfg_data_i;
    end
  end

  always_comb begin
    logic       advance;
    logic [1:0] c;
    logic       row_ok;
    logic [1:0] r;
    logic [PhaseW-1:0] d_full;
    logic [16:0] cnt_inc;
    logic [16:0] limit;

    phase_d = phase_q;
    wait_d  = wait_q;
    cnt_d   = cnt_q;
    found_d = found_q;
    col_d   = col_q;
    dig_d   = dig_q;
    seg_d   = seg_q;
    acc_d   = 1'b0;
    code_d  = 4'd0;
    push    = '0;
    advance = 1'b0;
    c       = phase_q[1:0];
    row_ok  = 1'b1;
    r       = 2'd0;
    d_full  = phase_q - PhaseDisp;
    rd_idx  = (d_full > PhaseW'(DIGITS - 1)) ? DigW'(DIGITS - 1) : d_full[DigW-1:0];
    cnt_inc = {1'b0, cnt_q} + 17'd1;
    limit   = {1'b0, (dwell_q == 16'd0) ? 16'd1 : dwell_q};

    unique case (row_sense_i)
      4'he: r = 2'd0;
      4'hd: r = 2'd1;
      4'hb: r = 2'd2;
      4'h7: r = 2'd3;
      default: row_ok = 1'b0;
    endcase

    if (in_fire) begin
      if (phase_q < PhaseDisp) begin
        col_d = ~(4'b0001 << c);
        if (!wait_q) begin
          if (row_sense_i != 4'hf) begin
            wait_d = 1'b1;
            cnt_d  = 16'd0;
          end else begin
            advance = 1'b1;
          end
        end else if (cnt_q < debounce_q) begin
          cnt_d = cnt_inc[15:0];
        end else begin
          if (row_ok) found_d = {1'b1, key_map({c, r})};
          wait_d  = 1'b0;
          cnt_d   = 16'd0;
          advance = 1'b1;
        end
        if (advance) begin
          if (c == 2'd3) begin
            if (found_d[4]) begin
              acc_d    = 1'b1;
              code_d   = found_d[3:0];
              push.en  = 1'b1;
              push.key = found_d[3:0];
            end
            found_d = 5'd0;
            cnt_d   = 16'd0;
            phase_d = PhaseDisp;
          end else begin
            phase_d = phase_q + PhaseW'(1);
          end
        end
      end else begin
        dig_d = (32'(rd_idx) < 32'd8) ? ~(8'h01 << rd_idx) : 8'hff;
        seg_d = rd_seg;
        if (cnt_inc >= limit) begin
          cnt_d   = 16'd0;
          phase_d = (phase_q >= PhaseLast) ? PhaseW'(0) : phase_q + PhaseW'(1);
        end else begin
          cnt_d = cnt_inc[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      wait_q      <= 1'b0;
      cnt_q       <= '0;
      found_q     <= '0;
      col_q       <= 4'hf;
      dig_q       <= 8'hff;
      seg_q       <= 8'hff;
      acc_q       <= 1'b0;
      code_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q <= phase_d;
        wait_q  <= wait_d;
        cnt_q   <= cnt_d;
        found_q <= found_d;
        col_q   <= col_d;
        dig_q   <= dig_d;
        seg_q   <= seg_d;
        acc_q   <= acc_d;
        code_q  <= code_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  kpsd_display_store #(
    .DIGITS(DIGITS)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rd_idx_i(rd_idx),
    .rd_seg_o(rd_seg)
  );

  assign out_valid_o       = out_valid_q;
  assign column_drive_o    = col_q;
  assign digit_select_o    = dig_q;
  assign segment_pattern_o = seg_q;
  assign key_accepted_o    = acc_q;
  assign key_code_o        = code_q;

`ifndef SYNTH
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PhaseLast) else $error("frame phase out of range");
  a_wait_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wait_q |-> phase_q < PhaseDisp) else $error("debounce wait outside scan");
  a_key_at_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && key_accepted_o) |-> (column_drive_o == 4'h7 && phase_q == PhaseDisp))
    else $error("key strobe not at end of last column scan");
  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !key_accepted_o) |-> key_code_o == 4'd0)
    else $error("key code without strobe");
  a_found_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q >= PhaseDisp |-> found_q == 5'd0) else $error("found key kept into display");
`endif

endmodule

// ===== tb/tb_keypad_to_scrolling_segment_display.sv =====
module tb_keypad_to_scrolling_segment_display import kpsd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DIGITS = DIGITS_DEFAULT;
  localparam int unsigned SCAN_PHASES = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = '1;
  localparam logic [63:0] KEYPAD_MAP = 64'hFEDC_B369_0258_A147;
  localparam logic [127:0] SEGMENT_FONT = 128'h71_79_5e_39_7c_77_6f_7f_07_7d_6d_66_4f_5b_06_3f;

  typedef struct {
    logic [3:0] column;
    logic [7:0] digits;
    logic [7:0] segments;
    logic       strobe;
    logic [3:0] key;
  } display_lines_t;

  class kpsd_scoreboard;
    int unsigned debounce_ticks = DEBOUNCE_RESET;
    int unsigned dwell_ticks = DWELL_RESET;
    int unsigned frame_phase = 0;
    bit debouncing = 0;
    int unsigned tick_count = 0;
    bit have_key = 0;
    logic [3:0] found_key = '0;
    logic [7:0] shown [DIGITS];
    logic [3:0] held_column = 4'hF;
    logic [7:0] held_digits = 8'hFF;
    logic [7:0] held_segments = 8'hFF;
    display_lines_t expected_lines [$];
    int unsigned errors = 0;
    int unsigned ticks_seen = 0;
    int unsigned keys_scrolled = 0;

    function new();
      foreach (shown[i]) shown[i] = SEG_BLANK;
    endfunction

    function void set_config(input logic [15:0] debounce, input logic [15:0] dwell);
      debounce_ticks = debounce;
      dwell_ticks = dwell;
    endfunction

    function int unsigned pending();
      return expected_lines.size();
    endfunction

    function void note_tick(input logic [3:0] rows);
      display_lines_t r;
      bit advance;
      int unsigned c, d, limit;
      int row;
      r.column = held_column;
      r.digits = held_digits;
      r.segments = held_segments;
      r.strobe = 1'b0;
      r.key = '0;
      ticks_seen++;
      if (frame_phase < SCAN_PHASES) begin
        c = frame_phase;
        advance = 0;
        held_column = ~(4'b0001 << c);
        r.column = held_column;
        if (!debouncing) begin
          if (rows != 4'hF) begin
            debouncing = 1;
            tick_count = 0;
          end else begin
            advance = 1;
          end
        end else if (tick_count < debounce_ticks) begin
          tick_count++;
        end else begin
          case (rows)
            4'hE: row = 0;
            4'hD: row = 1;
            4'hB: row = 2;
            4'h7: row = 3;
            default: row = -1;
          endcase
          if (row >= 0) begin
            have_key = 1;
            found_key = KEYPAD_MAP[(c * 4 + row) * 4 +: 4];
          end
          debouncing = 0;
          tick_count = 0;
          advance = 1;
        end
        if (advance) begin
          if (c == SCAN_PHASES - 1) begin
            if (have_key) begin
              r.strobe = 1'b1;
              r.key = found_key;
              for (int i = 0; i < DIGITS - 1; i++) shown[i] = shown[i + 1];
              shown[DIGITS - 1] = SEGMENT_FONT[found_key * 8 +: 8];
              keys_scrolled++;
            end
            have_key = 0;
            tick_count = 0;
            frame_phase = SCAN_PHASES;
          end else begin
            frame_phase = c + 1;
          end
        end
      end else begin
        d = frame_phase - SCAN_PHASES;
        limit = (dwell_ticks == 0) ? 1 : dwell_ticks;
        held_digits = ~(8'b0000_0001 << d);
        held_segments = shown[d];
        r.digits = held_digits;
        r.segments = held_segments;
        tick_count++;
        if (tick_count >= limit) begin
          tick_count = 0;
          frame_phase = (d + 1 >= DIGITS) ? 0 : frame_phase + 1;
        end
      end
      expected_lines.push_back(r);
    endfunction

    function void compare(input string field, input int unsigned want, input int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_lines(input logic [3:0] column, input logic [7:0] digits,
                              input logic [7:0] segments, input logic strobe,
                              input logic [3:0] key);
      display_lines_t e;
      if (expected_lines.size() == 0) begin
        $display("%0t: unexpected result, column 0x%0h digits 0x%0h segments 0x%0h",
                 $time, column, digits, segments);
        errors++;
        return;
      end
      e = expected_lines.pop_front();
      if ($isunknown({column, digits, segments, strobe, key})) begin
        $display("%0t: unknown bits in result", $time);
        errors++;
      end
      compare("column_drive", e.column, column);
      compare("digit_select", e.digits, digits);
      compare("segment_pattern", e.segments, segments);
      compare("key_accepted", e.strobe, strobe);
      compare("key_code", e.key, key);
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [15:0]            cfg_data_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [3:0]             row_sense_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [3:0]             column_drive_o;
  logic [7:0]             digit_select_o;
  logic [7:0]             segment_pattern_o;
  logic                   key_accepted_o;
  logic [3:0]             key_code_o;

  kpsd_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;
  int unsigned settings_used = 1;

  keypad_to_scrolling_segment_display dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .row_sense_i,
    .out_valid_o,
    .out_ready_i,
    .column_drive_o,
    .digit_select_o,
    .segment_pattern_o,
    .key_accepted_o,
    .key_code_o
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_tick(row_sense_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_lines(column_drive_o, digit_select_o, segment_pattern_o,
                       key_accepted_o, key_code_o);
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic drive_tick(input logic [3:0] rows);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    row_sense_i <= rows;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic configure(input logic [15:0] debounce, input logic [15:0] dwell);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_DEBOUNCE;
    cfg_data_i <= debounce;
    @(posedge clk_i);
    cfg_index_i <= REG_DWELL;
    cfg_data_i <= dwell;
    @(posedge clk_i);
    cfg_index_i <= REG_SPARE;
    cfg_data_i <= 16'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_config(debounce, dwell);
    settings_used++;
  endtask

  task automatic press_sequences(input int unsigned count);
    int unsigned sent, kind, hold_len;
    logic [3:0] pattern;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        pattern = ~(4'b0001 << $urandom_range(3));
        hold_len = $urandom_range(1, 10);
      end else if (kind < 75) begin
        pattern = 4'hF;
        hold_len = $urandom_range(1, 8);
      end else begin
        pattern = 4'($urandom_range(15));
        hold_len = $urandom_range(1, 6);
      end
      repeat (hold_len) begin
        drive_tick((kind >= 88) ? 4'($urandom_range(15)) : pattern);
        sent++;
      end
    end
  endtask

  initial begin
    logic [3:0] directed [] = '{4'hF, 4'hE, 4'hE, 4'hD, 4'hD, 4'hB, 4'hB, 4'h7, 4'h7,
                                4'h0, 4'h0, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF,
                                4'hF, 4'h3, 4'h3, 4'hC, 4'hC, 4'hE, 4'hE};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    row_sense_i = 4'hF;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    repeat (10) drive_tick(4'hF);

    configure(16'd0, 16'd1);
    foreach (directed[i]) drive_tick(directed[i]);

    configure(16'd1, 16'd2);
    send_idle_pct = 8;
    recv_idle_pct = 68;
    press_sequences(215);

    configure(16'd0, 16'd0);
    send_idle_pct = 68;
    recv_idle_pct = 8;
    press_sequences(215);

    configure(16'd3, 16'd3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 300;
    press_sequences(215);

    configure(16'hFFFF, 16'hFFFF);
    press_sequences(20);

    configure(16'd0, 16'hFFFF);
    press_sequences(30);

    configure(16'd2, 16'd1);
    send_idle_pct = 8;
    recv_idle_pct = 8;
    press_sequences(80);

    wait_drained();
    repeat (12) @(posedge clk_i);

    $display("covered %0d ticks over %0d register settings, %0d keys scrolled in",
             sb.ticks_seen, settings_used, sb.keys_scrolled);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/kpsd_pkg.sv
hdl/kpsd_display_store.sv
hdl/keypad_to_scrolling_segment_display.sv
tb/tb_keypad_to_scrolling_segment_display.sv
